FILE: src/complex_arith_unit_macros.svh
// Assertion macros for the complex arithmetic unit.
`ifndef COMPLEX_ARITH_UNIT_MACROS_SVH
`define COMPLEX_ARITH_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define CAU_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("complex_arith_unit check failed");
`define CAU_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("complex_arith_unit check failed");
`else
`define CAU_ASSERT(label, clk, rst_n, prop)
`define CAU_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

FILE: src/cau_pkg.sv
// Shared types and constants of the complex arithmetic unit.
`default_nettype none
package cau_pkg;
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } cau_op_t;

  localparam int OUT_FRAC = 16;
  localparam int QUO_BITS = 33;
  localparam int RES_WIDTH = 32;
endpackage
`default_nettype wire

FILE: src/complex_arith_unit.sv
// Top level of the complex add, subtract, multiply and divide unit.
//
//   channel   handshake         payload
//   input     in_push/in_full   in_op, in_first_re/im, in_second_re/im
//   result    out_pop/out_empty out_result_re/im, out_zero_divisor, out_saturated
//
// One beat per cycle sustained while the result queue has room; every item
// passes the 33 quotient-bit stages of the divider.
// Reset is synchronous; the queues come up empty.
// A held result stalls only the back pipeline; the front keeps accepting
// until the four-entry middle queue is full and the front register holds a beat.
`default_nettype none
`include "complex_arith_unit_macros.svh"
module complex_arith_unit import cau_pkg::*; #(
  parameter int IN_WIDTH  = 16,
  parameter int FRAC_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic [1:0]                  in_op,
  input  logic signed [IN_WIDTH-1:0]  in_first_re,
  input  logic signed [IN_WIDTH-1:0]  in_first_im,
  input  logic signed [IN_WIDTH-1:0]  in_second_re,
  input  logic signed [IN_WIDTH-1:0]  in_second_im,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic signed [RES_WIDTH-1:0] out_result_re,
  output logic signed [RES_WIDTH-1:0] out_result_im,
  output logic                        out_zero_divisor,
  output logic                        out_saturated
);
  localparam int IW = 3 + 16 * IN_WIDTH;

  logic          fq_push, fq_full, mq_pop, mq_empty;
  logic [IW-1:0] fq_data, mq_data;
  logic          zero_parts, re_at_lim, im_at_lim;

  cau_front #(.IN_WIDTH(IN_WIDTH)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_op(in_op),
    .in_first_re(in_first_re), .in_first_im(in_first_im),
    .in_second_re(in_second_re), .in_second_im(in_second_im),
    .mq_full(fq_full), .mq_push(fq_push), .mq_data(fq_data)
  );

  cau_queue #(.WIDTH(IW), .DEPTH(4)) u_mid_q (
    .clk(clk), .rst_n(rst_n),
    .push(fq_push), .wdata(fq_data), .full(fq_full),
    .pop(mq_pop), .rdata(mq_data), .empty(mq_empty)
  );

  cau_back #(.IN_WIDTH(IN_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .mq_empty(mq_empty), .mq_data(mq_data), .mq_pop(mq_pop),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_result_re(out_result_re), .out_result_im(out_result_im),
    .out_zero_divisor(out_zero_divisor), .out_saturated(out_saturated)
  );

  assign zero_parts = (out_result_re == '0) && (out_result_im == '0) && !out_saturated;
  assign re_at_lim  = (out_result_re == 32'sh7fffffff) || (out_result_re == 32'sh80000000);
  assign im_at_lim  = (out_result_im == 32'sh7fffffff) || (out_result_im == 32'sh80000000);

  `CAU_ASSERT(a_zdiv_clean, clk, rst_n, (!out_empty && out_zero_divisor) |-> zero_parts)
  `CAU_ASSERT(a_sat_at_limit, clk, rst_n, (!out_empty && out_saturated) |-> (re_at_lim || im_at_lim))
  `CAU_ASSERT(a_full_needs_mid, clk, rst_n, in_full |-> fq_full)
endmodule
`default_nettype wire

FILE: src/cau_queue.sv
// Small register queue with count; DEPTH is a power of two.
`default_nettype none
module cau_queue import cau_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]      cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + AW'(1) : rd_ptr_r;
    unique case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + (AW+1)'(1);
      2'b01:   cnt_nxt = cnt_r - (AW+1)'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end
endmodule
`default_nettype wire

FILE: src/cau_front.sv
// Front end: accept a beat, flag zero divisor, form the part products.
`default_nettype none
module cau_front import cau_pkg::*; #(
  parameter int IN_WIDTH = 16,
  localparam int IW = 3 + 16 * IN_WIDTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  output logic                       in_full,
  input  logic [1:0]                 in_op,
  input  logic signed [IN_WIDTH-1:0] in_first_re,
  input  logic signed [IN_WIDTH-1:0] in_first_im,
  input  logic signed [IN_WIDTH-1:0] in_second_re,
  input  logic signed [IN_WIDTH-1:0] in_second_im,
  input  logic                       mq_full,
  output logic                       mq_push,
  output logic [IW-1:0]              mq_data
);
  localparam int PW = 2 * IN_WIDTH;

  logic          f_valid_r, f_valid_nxt;
  logic [IW-1:0] f_data_r;
  logic          accept;
  logic          zdiv;
  logic signed [PW-1:0] pr, qs, ps, qr, rr, ss;
  cau_op_t       op;

  assign op      = cau_op_t'(in_op);
  assign mq_push = f_valid_r && !mq_full;
  assign in_full = f_valid_r && mq_full;
  assign accept  = in_push && !in_full;
  assign mq_data = f_data_r;

  assign zdiv = (in_second_re == '0) && (in_second_im == '0);
  assign pr = in_first_re * in_second_re;
  assign qs = in_first_im * in_second_im;
  assign ps = in_first_re * in_second_im;
  assign qr = in_first_im * in_second_re;
  assign rr = in_second_re * in_second_re;
  assign ss = in_second_im * in_second_im;

  assign f_valid_nxt = accept || (f_valid_r && !mq_push);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_data_r <= {op, zdiv, in_first_re, in_first_im, in_second_re, in_second_im,
                   pr, qs, ps, qr, rr, ss};
    end
  end
endmodule
`default_nettype wire

FILE: src/cau_div.sv
// Pipelined restoring divider: one quotient bit per stage, overflow flag.
`default_nettype none
module cau_div import cau_pkg::*; #(
  parameter int MW = 32
) (
  input  logic                clk,
  input  logic                en,
  input  logic [MW-1:0]       num,
  input  logic [MW-1:0]       den,
  output logic [QUO_BITS-1:0] quo,
  output logic                ovf
);
  localparam int QB = QUO_BITS;

  logic [MW-1:0] rem_r [QB+1];
  logic [MW-1:0] den_r [QB+1];
  logic [QB-1:0] low_r [QB+1];
  logic [QB-1:0] quo_r [QB+1];
  logic          ovf_r [QB+1];
  logic [MW+OUT_FRAC-1:0] numx;
  logic [MW-1:0]          num_hi;

  assign numx   = {num, {OUT_FRAC{1'b0}}};
  assign num_hi = num >> (OUT_FRAC + 1);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num_hi;
      den_r[0] <= den;
      low_r[0] <= QB'(numx);
      quo_r[0] <= '0;
      ovf_r[0] <= (num_hi >= den);
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_stage
    logic [MW:0]   trial;
    logic          ge;
    logic [MW-1:0] rem_nxt;

    always_comb begin
      trial   = {rem_r[k-1], low_r[k-1][QB-1]};
      ge      = (trial >= {1'b0, den_r[k-1]});
      rem_nxt = ge ? MW'(trial - {1'b0, den_r[k-1]}) : trial[MW-1:0];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        den_r[k] <= den_r[k-1];
        low_r[k] <= {low_r[k-1][QB-2:0], 1'b0};
        quo_r[k] <= {quo_r[k-1][QB-2:0], ge};
        ovf_r[k] <= ovf_r[k-1];
      end
    end
  end

  assign quo = quo_r[QB];
  assign ovf = ovf_r[QB];
endmodule
`default_nettype wire

FILE: src/cau_back.sv
// Back end: combine products, divide, scale, saturate, queue results.
`default_nettype none
module cau_back import cau_pkg::*; #(
  parameter int IN_WIDTH  = 16,
  parameter int FRAC_BITS = 8,
  localparam int IW = 3 + 16 * IN_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        mq_empty,
  input  logic [IW-1:0]               mq_data,
  output logic                        mq_pop,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic signed [RES_WIDTH-1:0] out_result_re,
  output logic signed [RES_WIDTH-1:0] out_result_im,
  output logic                        out_zero_divisor,
  output logic                        out_saturated
);
  localparam int W   = IN_WIDTH;
  localparam int PW  = 2 * W;
  localparam int MW  = 2 * W;
  localparam int SW  = 2 * W + 1;
  localparam int XW  = MW + OUT_FRAC;
  localparam int DL  = QUO_BITS + 1;
  localparam int OW  = 2 * RES_WIDTH + 2;

  typedef struct packed {
    logic [1:0]    op;
    logic          zd;
    logic          na;
    logic          nb;
    logic [MW-1:0] ma;
    logic [MW-1:0] mb;
  } pass_t;

  logic [1:0]            op_w;
  logic                  zd_w;
  logic signed [W-1:0]   p, q, r, s;
  logic signed [PW-1:0]  pr, qs, ps, qr, rr, ss;
  logic signed [SW-1:0]  a_w, b_w;
  pass_t                 s1_nxt;
  pass_t                 s1_r;
  logic [MW-1:0]         den_nxt, den_r;
  logic                  s1_v_r;
  pass_t                 d_r [DL];
  logic [DL-1:0]         dv_r;
  logic                  en;
  logic                  oq_full;
  logic [QUO_BITS-1:0]   quo_a, quo_b;
  logic                  ovf_a, ovf_b;
  logic [RES_WIDTH:0]    fa, fb;
  logic [OW-1:0]         oq_wdata, oq_rdata;
  pass_t                 tail;

  assign {op_w, zd_w, p, q, r, s, pr, qs, ps, qr, rr, ss} = mq_data;

  assign en     = !oq_full;
  assign mq_pop = en && !mq_empty;

  always_comb begin
    unique case (cau_op_t'(op_w))
      OP_ADD: begin
        a_w = SW'(p) + SW'(r);
        b_w = SW'(q) + SW'(s);
      end
      OP_SUB: begin
        a_w = SW'(p) - SW'(r);
        b_w = SW'(q) - SW'(s);
      end
      OP_MUL: begin
        a_w = SW'(pr) - SW'(qs);
        b_w = SW'(ps) + SW'(qr);
      end
      default: begin
        a_w = SW'(pr) + SW'(qs);
        b_w = SW'(qr) - SW'(ps);
      end
    endcase
    s1_nxt.op = op_w;
    s1_nxt.zd = zd_w && (cau_op_t'(op_w) == OP_DIV);
    s1_nxt.na = a_w[SW-1];
    s1_nxt.nb = b_w[SW-1];
    s1_nxt.ma = MW'(a_w[SW-1] ? -a_w : a_w);
    s1_nxt.mb = MW'(b_w[SW-1] ? -b_w : b_w);
    den_nxt   = MW'($unsigned(rr)) + MW'($unsigned(ss));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      dv_r   <= '0;
    end else if (en) begin
      s1_v_r <= !mq_empty;
      dv_r   <= {dv_r[DL-2:0], s1_v_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r  <= s1_nxt;
      den_r <= den_nxt;
      d_r[0] <= s1_r;
      for (int k = 1; k < DL; k++) begin
        d_r[k] <= d_r[k-1];
      end
    end
  end

  cau_div #(.MW(MW)) u_div_re (
    .clk(clk), .en(en), .num(s1_r.ma), .den(den_r), .quo(quo_a), .ovf(ovf_a)
  );

  cau_div #(.MW(MW)) u_div_im (
    .clk(clk), .en(en), .num(s1_r.mb), .den(den_r), .quo(quo_b), .ovf(ovf_b)
  );

  function automatic logic [RES_WIDTH:0] finish(input logic neg, input logic [MW-1:0] m,
                                                input logic [1:0] op,
                                                input logic [QUO_BITS-1:0] quo,
                                                input logic ovf);
    logic [XW-1:0]        sc;
    logic [RES_WIDTH-1:0] lim;
    logic [RES_WIDTH-1:0] mag;
    logic                 over;
    lim = neg ? {1'b1, {(RES_WIDTH-1){1'b0}}} : {1'b0, {(RES_WIDTH-1){1'b1}}};
    if (cau_op_t'(op) == OP_DIV) begin
      sc   = '0;
      over = ovf || (quo > QUO_BITS'(lim));
      mag  = quo[RES_WIDTH-1:0];
    end else begin
      if (cau_op_t'(op) == OP_MUL) begin
        sc = {m, {OUT_FRAC{1'b0}}} >> (2 * FRAC_BITS);
      end else begin
        sc = {m, {OUT_FRAC{1'b0}}} >> FRAC_BITS;
      end
      over = (sc > XW'(lim));
      mag  = sc[RES_WIDTH-1:0];
    end
    if (over) begin
      mag = lim;
    end
    return {over, neg ? -mag : mag};
  endfunction

  assign tail = d_r[DL-1];

  always_comb begin
    fa = finish(tail.na, tail.ma, tail.op, quo_a, ovf_a);
    fb = finish(tail.nb, tail.mb, tail.op, quo_b, ovf_b);
    if (tail.zd) begin
      oq_wdata = {{(2*RES_WIDTH){1'b0}}, 1'b1, 1'b0};
    end else begin
      oq_wdata = {fa[RES_WIDTH-1:0], fb[RES_WIDTH-1:0], 1'b0,
                  fa[RES_WIDTH] || fb[RES_WIDTH]};
    end
  end

  cau_queue #(.WIDTH(OW), .DEPTH(2)) u_out_q (
    .clk(clk), .rst_n(rst_n),
    .push(en && dv_r[DL-1]), .wdata(oq_wdata), .full(oq_full),
    .pop(out_pop), .rdata(oq_rdata), .empty(out_empty)
  );

  assign out_result_re    = oq_rdata[OW-1 -: RES_WIDTH];
  assign out_result_im    = oq_rdata[2 +: RES_WIDTH];
  assign out_zero_divisor = oq_rdata[1];
  assign out_saturated    = oq_rdata[0];
endmodule
`default_nettype wire
